// ----- hw/rtl/mwca_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and defaults of the mass-weighted covariance accumulator.
package mwca_pkg;

	localparam int unsigned MAX_ELEMENTS_DEF = 96;
	localparam int unsigned MAX_FRAMES_DEF   = 32767;
	localparam int unsigned QUEUE_DEPTH      = 2;
	localparam int unsigned CFG_AW           = 3;
	localparam logic [15:0] WEIGHT_ONE       = 16'd256;
	localparam logic [6:0]  ELEMENT_COUNT_RST = 7'd96;
	localparam logic [1:0]  GROUP_SIZE_RST    = 2'd3;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_WEIGHT = 2'd1,
		OP_SAMPLE = 2'd2,
		OP_READ   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_NO_FRAMES = 2'd1,
		STS_BAD_INDEX = 2'd2,
		STS_FULL      = 2'd3
	} status_t;

	typedef enum logic {
		REG_ELEMENT_COUNT = 1'b0,
		REG_GROUP_SIZE    = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [23:0] sample_value;
		logic [6:0]         weight_index;
		logic [15:0]        weight_value;
		logic [6:0]         entry_row;
		logic [6:0]         entry_col;
	} item_t;

	typedef struct packed {
		logic signed [63:0] covariance_value;
		logic [1:0]         status;
	} result_t;

	typedef enum logic [2:0] {
		CMD_CLEAR,
		CMD_WEIGHT,
		CMD_SAMPLE,
		CMD_READ,
		CMD_REJECT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic signed [23:0] sample;
		logic [6:0]         widx;
		logic [15:0]        weight;
		logic [6:0]         row;
		logic [6:0]         col;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_SAMP,
		ST_DRAIN,
		ST_RD_ADDR,
		ST_RD_MEM,
		ST_RD_WAIT,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_COV_MUL,
		ST_COV_SUB,
		ST_SQRT,
		ST_SQRT_FIX,
		ST_SCALE,
		ST_RESULT
	} back_state_t;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quotient;
	} div_rsp_t;

endpackage

// ----- hw/rtl/mass_weighted_covariance_accumulator.sv -----
`timescale 1ns / 1ps
// Top level of the mass-weighted streaming covariance accumulator.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-----------------------
//  request   | push / full               | item   (item_t)
//  result    | pop / empty               | result (result_t)
//  config    | psel, penable, pwrite     | paddr, pwdata, prdata
//
//  Sample: one product-sum read-modify-write per cycle for frame position p.
//  Read: three passes of the serial divider and a 16-step square root.
//  Clear: one product-sum entry per cycle.
//  After reset a sweep clearing MAX_ELEMENTS*(MAX_ELEMENTS+1)/2 entries keeps full high.
//  Requests queue ahead of the back end; results wait in a two-entry queue.
module mass_weighted_covariance_accumulator import mwca_pkg::*; #(
	parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF,
	parameter int unsigned MAX_FRAMES   = MAX_FRAMES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  item_t             item,
	output logic              full,
	input  logic              pop,
	output result_t           result,
	output logic              empty,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

	logic [6:0] ec_q;
	logic [1:0] gs_q;
	logic cfg_wr;
	logic [CW-1:0] n_eff;
	logic [1:0] g_eff;
	logic init_busy, cmd_valid, cmd_pop, res_full, res_push;
	cmd_t cmd;
	result_t res;
	logic [$bits(result_t)-1:0] res_rdata;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ec_q <= ELEMENT_COUNT_RST;
			gs_q <= GROUP_SIZE_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[2]))
				REG_ELEMENT_COUNT: ec_q <= pwdata[6:0];
				REG_GROUP_SIZE:    gs_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_ELEMENT_COUNT: prdata = {25'b0, ec_q};
			REG_GROUP_SIZE:    prdata = {30'b0, gs_q};
			default:           prdata = '0;
		endcase
		if (ec_q == '0) begin
			n_eff = CW'(1);
		end else if (32'(ec_q) > MAX_ELEMENTS) begin
			n_eff = CW'(MAX_ELEMENTS);
		end else begin
			n_eff = CW'(ec_q);
		end
		g_eff = (gs_q == '0) ? 2'd1 : gs_q;
	end

	mwca_front #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.hold     (init_busy),
		.n_eff    (n_eff),
		.cmd_pop  (cmd_pop),
		.cmd_valid(cmd_valid),
		.cmd      (cmd)
	);

	mwca_back #(
		.MAX_ELEMENTS(MAX_ELEMENTS),
		.MAX_FRAMES  (MAX_FRAMES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_wr),
		.n_eff    (n_eff),
		.g_eff    (g_eff),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res),
		.init_busy(init_busy)
	);

	mwca_fifo #(
		.W    ($bits(result_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (res_push),
		.wdata (res),
		.full  (res_full),
		.rd    (pop),
		.rdata (res_rdata),
		.empty (empty)
	);

	assign result = result_t'(res_rdata);

endmodule

// ----- hw/rtl/mwca_fifo.sv -----
`timescale 1ns / 1ps
// Small register queue used between the front, the back and the result port.
module mwca_fifo import mwca_pkg::*; #(
	parameter int unsigned W     = 8,
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         rd,
	output logic [W-1:0] rdata,
	output logic         empty
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0] mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic do_wr, do_rd;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

endmodule

// ----- hw/rtl/mwca_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts requests, checks indices and queues commands for the back end.
module mwca_front import mwca_pkg::*; #(
	parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF,
	localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  item_t         item,
	output logic          full,
	input  logic          hold,
	input  logic [CW-1:0] n_eff,
	input  logic          cmd_pop,
	output logic          cmd_valid,
	output cmd_t          cmd
);
	cmd_t cmd_in;
	logic q_full, q_empty;
	logic [$bits(cmd_t)-1:0] q_rdata;

	always_comb begin
		cmd_in        = '0;
		cmd_in.sample = item.sample_value;
		cmd_in.widx   = item.weight_index;
		cmd_in.weight = item.weight_value;
		cmd_in.row    = item.entry_row;
		cmd_in.col    = item.entry_col;
		unique case (opcode_t'(item.opcode))
			OP_CLEAR:  cmd_in.kind = CMD_CLEAR;
			OP_WEIGHT: cmd_in.kind = (32'(item.weight_index) < MAX_ELEMENTS) ?
				CMD_WEIGHT : CMD_REJECT;
			OP_SAMPLE: cmd_in.kind = CMD_SAMPLE;
			OP_READ: begin
				if ((item.entry_row > item.entry_col) ||
				    (32'(item.entry_col) >= 32'(n_eff))) begin
					cmd_in.kind = CMD_REJECT;
				end else begin
					cmd_in.kind = CMD_READ;
				end
			end
			default:   cmd_in.kind = CMD_REJECT;
		endcase
	end

	mwca_fifo #(
		.W     ($bits(cmd_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (push && !full),
		.wdata (cmd_in),
		.full  (q_full),
		.rd    (cmd_pop),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	assign full      = q_full || hold;
	assign cmd_valid = !q_empty;
	assign cmd       = cmd_t'(q_rdata);

endmodule

// ----- hw/rtl/mwca_div.sv -----
`timescale 1ns / 1ps
// Serial restoring divider, one quotient bit per cycle, 64-bit dividend.
module mwca_div import mwca_pkg::*; #(
	parameter int unsigned DW = 15
) (
	input  logic          clk,
	input  logic          arst_n,
	input  div_req_t      req,
	input  logic [DW-1:0] divisor,
	output div_rsp_t      rsp
);
	logic [63:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [5:0] cnt_q;
	logic busy_q, done_q;
	logic [DW:0] rem_sh, diff;
	logic ge;

	always_comb begin
		rem_sh = {rem_q, quo_q[63]};
		diff   = rem_sh - {1'b0, divisor};
		ge     = (rem_sh >= {1'b0, divisor});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[62:0], ge};
			rem_q <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	assert property (@(posedge clk) disable iff (!arst_n) req.start |-> !busy_q)
		else $error("divider restarted while busy");

endmodule

// ----- hw/rtl/mwca_back.sv -----
`timescale 1ns / 1ps
// Back end: sample accumulation, clearing sweep and on-demand covariance evaluation.
module mwca_back import mwca_pkg::*; #(
	parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF,
	parameter int unsigned MAX_FRAMES   = MAX_FRAMES_DEF,
	localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr,
	input  logic [CW-1:0] n_eff,
	input  logic [1:0]    g_eff,
	input  logic          cmd_valid,
	input  cmd_t          cmd,
	output logic          cmd_pop,
	input  logic          res_full,
	output logic          res_push,
	output result_t       res,
	output logic          init_busy
);
	localparam int unsigned EW  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int unsigned FW  = $clog2(MAX_FRAMES + 1);
	localparam int unsigned TRI = MAX_ELEMENTS * (MAX_ELEMENTS + 1) / 2;
	localparam int unsigned TAW = (TRI > 1) ? $clog2(TRI) : 1;

	// storage
	logic [63:0] ps_mem [TRI];
	logic signed [23:0] fb_mem [MAX_ELEMENTS];
	logic [39:0] es_mem [MAX_ELEMENTS];
	logic [15:0] wt_mem [MAX_ELEMENTS];
	logic [MAX_ELEMENTS-1:0] es_vld_q, wt_vld_q;

	back_state_t state_q, state_d;
	logic [TAW-1:0] clr_q, base_q, pbase_q, tri_q;
	logic clr_res_q;
	logic [EW-1:0] pos_q, p_q, i_q, wgr_q, wgc_q;
	logic [FW-1:0] fc_q;
	cmd_t cmd_q;
	result_t res_q;

	logic v_s1, v_s2;
	logic [TAW-1:0] addr_s1, addr_s2;
	logic signed [47:0] prod_s2;
	logic [63:0] ps_s2;

	logic [63:0] ps_rd, ps_val_q;
	logic signed [23:0] fb_rd;
	logic [39:0] es_rd_a, es_rd_b, er_q, ec_q;
	logic es_va_a, es_va_b, wt_va_a, wt_va_b;
	logic [15:0] wt_rd_a, wt_rd_b, wa_q, wb_q;

	logic [1:0] dsel_q;
	logic signed [63:0] avg_q, mr_q, mc_q, mm_q, cov_q;
	logic [31:0] x_q;
	logic [15:0] sq_r_q;
	logic [3:0] bit_q;
	logic [16:0] m_q;
	logic [63:0] mag_q, prod_q, acc_q;
	logic neg_q;
	logic [2:0] sc_q;

	// combinational
	logic ps_we, es_we, fb_we, wt_we;
	logic [TAW-1:0] ps_waddr, ps_raddr;
	logic [63:0] ps_wdata;
	logic [EW-1:0] es_raddr_a, p_eff, row_e, col_e, widx_e;
	logic [TAW-1:0] base_eff;
	logic frames_full, last_elem;
	logic [63:0] opnd, opnd_mag;
	div_req_t div_req;
	div_rsp_t div_rsp;
	logic [63:0] quo_s;
	logic [2*EW:0] tri_prod;
	logic [15:0] sq_t;
	logic [31:0] sq_tt, sq_rr;
	logic [27:0] sc_a;
	logic [44:0] sc_prod;

	function automatic logic [EW-1:0] group_of(input logic [EW-1:0] idx, input logic [1:0] g);
		logic [EW+8:0] m3;
		begin
			m3 = (EW+9)'(idx) * (EW+9)'(171);
			case (g)
				2'd2:    group_of = idx >> 1;
				2'd3:    group_of = EW'(m3 >> 9);
				default: group_of = idx;
			endcase
		end
	endfunction

	assign row_e       = EW'(cmd_q.row);
	assign col_e       = EW'(cmd_q.col);
	assign widx_e      = EW'(cmd_q.widx);
	assign p_eff       = (CW'(pos_q) >= n_eff) ? '0 : pos_q;
	assign base_eff    = (CW'(pos_q) >= n_eff) ? '0 : base_q;
	assign frames_full = (fc_q == FW'(MAX_FRAMES));
	assign last_elem   = ((CW'(p_q) + CW'(1)) >= n_eff);
	assign tri_prod    = (2*EW+1)'(col_e) * ((2*EW+1)'(col_e) + (2*EW+1)'(1));
	assign sq_t        = sq_r_q | (16'd1 << bit_q);
	assign sq_tt       = {16'b0, sq_t} * {16'b0, sq_t};
	assign sq_rr       = {16'b0, sq_r_q} * {16'b0, sq_r_q};
	assign sc_prod     = sc_a * m_q;

	always_comb begin
		case (dsel_q)
			2'd0:    opnd = ps_val_q;
			2'd1:    opnd = {{24{er_q[39]}}, er_q};
			default: opnd = {{24{ec_q[39]}}, ec_q};
		endcase
		opnd_mag = opnd[63] ? (64'd0 - opnd) : opnd;
		quo_s    = opnd[63] ? (64'd0 - div_rsp.quotient) : div_rsp.quotient;
	end

	always_comb begin
		case (sc_q)
			3'd0:    sc_a = mag_q[35:8];
			3'd1:    sc_a = mag_q[63:36];
			default: sc_a = {20'b0, mag_q[7:0]};
		endcase
	end

	mwca_div #(.DW(FW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.divisor(fc_q),
		.rsp    (div_rsp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == TAW'(TRI - 1)) begin
				state_d = clr_res_q ? ST_RESULT : ST_IDLE;
			end
			ST_IDLE: if (cmd_valid) begin
				state_d = ST_DECODE;
			end
			ST_DECODE: begin
				unique case (cmd_q.kind)
					CMD_CLEAR:  state_d = ST_CLEAR;
					CMD_SAMPLE: state_d = frames_full ? ST_RESULT : ST_SAMP;
					CMD_READ:   state_d = (fc_q == '0) ? ST_RESULT : ST_RD_ADDR;
					default:    state_d = ST_RESULT;
				endcase
			end
			ST_SAMP: if (i_q == p_q) begin
				state_d = ST_DRAIN;
			end
			ST_DRAIN: if (!v_s1 && !v_s2) begin
				state_d = ST_RESULT;
			end
			ST_RD_ADDR: state_d = ST_RD_MEM;
			ST_RD_MEM:  state_d = ST_RD_WAIT;
			ST_RD_WAIT: state_d = ST_DIV_GO;
			ST_DIV_GO:  state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: if (div_rsp.done) begin
				state_d = (dsel_q == 2'd2) ? ST_COV_MUL : ST_DIV_GO;
			end
			ST_COV_MUL: state_d = ST_COV_SUB;
			ST_COV_SUB: state_d = ST_SQRT;
			ST_SQRT: if (bit_q == '0) begin
				state_d = ST_SQRT_FIX;
			end
			ST_SQRT_FIX: state_d = ST_SCALE;
			ST_SCALE: if (sc_q == 3'd4) begin
				state_d = ST_RESULT;
			end
			ST_RESULT: if (!res_full) begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and memory controls
	always_comb begin
		cmd_pop          = 1'b0;
		res_push         = 1'b0;
		init_busy        = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = opnd_mag + 64'(fc_q >> 1);
		ps_we            = v_s2;
		ps_waddr         = addr_s2;
		ps_wdata         = ps_s2 + {{16{prod_s2[47]}}, prod_s2};
		ps_raddr         = tri_q;
		es_raddr_a       = p_q;
		es_we            = 1'b0;
		fb_we            = 1'b0;
		wt_we            = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ps_we     = 1'b1;
				ps_waddr  = clr_q;
				ps_wdata  = '0;
				init_busy = !clr_res_q;
			end
			ST_IDLE:   cmd_pop = cmd_valid;
			ST_DECODE: begin
				es_raddr_a = p_eff;
				fb_we      = (cmd_q.kind == CMD_SAMPLE) && !frames_full;
				wt_we      = (cmd_q.kind == CMD_WEIGHT);
			end
			ST_SAMP:   ps_raddr = pbase_q + TAW'(i_q);
			ST_DRAIN:  es_we = !v_s1 && !v_s2;
			ST_RD_MEM: es_raddr_a = row_e;
			ST_DIV_GO: div_req.start = 1'b1;
			ST_RESULT: res_push = !res_full;
			default: ;
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (ps_we) begin
			ps_mem[ps_waddr] <= ps_wdata;
		end
		ps_rd <= ps_mem[ps_raddr];
	end

	always_ff @(posedge clk) begin
		if (fb_we) begin
			fb_mem[p_eff] <= cmd_q.sample;
		end
		fb_rd <= fb_mem[i_q];
	end

	always_ff @(posedge clk) begin
		if (es_we) begin
			es_mem[p_q] <= (es_va_a ? es_rd_a : 40'd0) +
				{{16{cmd_q.sample[23]}}, cmd_q.sample};
		end
		es_rd_a <= es_mem[es_raddr_a];
		es_rd_b <= es_mem[col_e];
		es_va_a <= es_vld_q[es_raddr_a];
		es_va_b <= es_vld_q[col_e];
	end

	always_ff @(posedge clk) begin
		if (wt_we) begin
			wt_mem[widx_e] <= cmd_q.weight;
		end
		wt_rd_a <= wt_mem[wgr_q];
		wt_rd_b <= wt_mem[wgc_q];
		wt_va_a <= wt_vld_q[wgr_q];
		wt_va_b <= wt_vld_q[wgc_q];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			clr_res_q <= 1'b0;
			pos_q     <= '0;
			base_q    <= '0;
			fc_q      <= '0;
			es_vld_q  <= '0;
			wt_vld_q  <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			i_q       <= '0;
			dsel_q    <= '0;
			bit_q     <= '0;
			sc_q      <= '0;
		end else begin
			state_q <= state_d;
			v_s1    <= (state_q == ST_SAMP);
			v_s2    <= v_s1;
			if (cfg_wr) begin
				pos_q  <= '0;
				base_q <= '0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == TAW'(TRI - 1)) begin
						clr_res_q <= 1'b0;
					end
				end
				ST_DECODE: begin
					i_q    <= '0;
					dsel_q <= '0;
					unique case (cmd_q.kind)
						CMD_CLEAR: begin
							clr_q     <= '0;
							clr_res_q <= 1'b1;
							pos_q     <= '0;
							base_q    <= '0;
							fc_q      <= '0;
							es_vld_q  <= '0;
						end
						CMD_WEIGHT: wt_vld_q[widx_e] <= 1'b1;
						default: ;
					endcase
				end
				ST_SAMP: i_q <= i_q + 1'b1;
				ST_DRAIN: if (!v_s1 && !v_s2) begin
					es_vld_q[p_q] <= 1'b1;
					if (last_elem) begin
						pos_q  <= '0;
						base_q <= '0;
						fc_q   <= fc_q + 1'b1;
					end else begin
						pos_q  <= p_q + 1'b1;
						base_q <= pbase_q + TAW'(p_q) + 1'b1;
					end
				end
				ST_DIV_WAIT: if (div_rsp.done) begin
					dsel_q <= dsel_q + 1'b1;
				end
				ST_COV_SUB:  bit_q <= 4'd15;
				ST_SQRT:     bit_q <= bit_q - 1'b1;
				ST_SQRT_FIX: sc_q <= '0;
				ST_SCALE:    sc_q <= sc_q + 1'b1;
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		addr_s1 <= ps_raddr;
		addr_s2 <= addr_s1;
		prod_s2 <= fb_rd * cmd_q.sample;
		ps_s2   <= ps_rd;
		unique case (state_q)
			ST_IDLE: if (cmd_valid) begin
				cmd_q <= cmd;
			end
			ST_DECODE: begin
				p_q     <= p_eff;
				pbase_q <= base_eff;
				res_q   <= '0;
				unique case (cmd_q.kind)
					CMD_REJECT: res_q.status <= STS_BAD_INDEX;
					CMD_SAMPLE: res_q.status <= frames_full ? STS_FULL : STS_OK;
					CMD_READ:   res_q.status <= (fc_q == '0) ? STS_NO_FRAMES : STS_OK;
					default:    res_q.status <= STS_OK;
				endcase
			end
			ST_RD_ADDR: begin
				tri_q <= TAW'((tri_prod >> 1) + (2*EW+1)'(row_e));
				wgr_q <= group_of(row_e, g_eff);
				wgc_q <= group_of(col_e, g_eff);
			end
			ST_RD_WAIT: begin
				ps_val_q <= ps_rd;
				er_q     <= es_va_a ? es_rd_a : 40'd0;
				ec_q     <= es_va_b ? es_rd_b : 40'd0;
				wa_q     <= wt_va_a ? wt_rd_a : WEIGHT_ONE;
				wb_q     <= wt_va_b ? wt_rd_b : WEIGHT_ONE;
			end
			ST_DIV_WAIT: if (div_rsp.done) begin
				case (dsel_q)
					2'd0:    avg_q <= quo_s;
					2'd1:    mr_q  <= quo_s;
					default: mc_q  <= quo_s;
				endcase
			end
			ST_COV_MUL: begin
				mm_q <= $signed(mr_q[31:0]) * $signed(mc_q[31:0]);
				x_q  <= wa_q * wb_q;
			end
			ST_COV_SUB: begin
				cov_q  <= avg_q - mm_q;
				sq_r_q <= '0;
			end
			ST_SQRT: if (sq_tt <= x_q) begin
				sq_r_q <= sq_t;
			end
			ST_SQRT_FIX: begin
				m_q   <= ((x_q - sq_rr) > {16'b0, sq_r_q}) ? {1'b0, sq_r_q} + 1'b1
					: {1'b0, sq_r_q};
				mag_q <= cov_q[63] ? (64'd0 - cov_q) : cov_q;
				neg_q <= cov_q[63];
			end
			ST_SCALE: begin
				case (sc_q)
					3'd0: prod_q <= 64'(sc_prod);
					3'd1: begin
						acc_q  <= prod_q;
						prod_q <= 64'(sc_prod);
					end
					3'd2: begin
						acc_q  <= acc_q + (prod_q << 28);
						prod_q <= 64'(sc_prod) + 64'd128;
					end
					3'd3: acc_q <= acc_q + (prod_q >> 8);
					default: res_q.covariance_value <= neg_q ? (64'd0 - acc_q) : acc_q;
				endcase
			end
			default: ;
		endcase
	end

	assign res = res_q;

	assert property (@(posedge clk) disable iff (!arst_n) (state_q == ST_CLEAR) |-> !v_s2)
		else $error("product write-back during clearing sweep");
	assert property (@(posedge clk) disable iff (!arst_n) fc_q <= FW'(MAX_FRAMES))
		else $error("frame count beyond limit");
	assert property (@(posedge clk) disable iff (!arst_n) (state_q == ST_SAMP) |-> (i_q <= p_q))
		else $error("sample sweep past its position");
	assert property (@(posedge clk) disable iff (!arst_n) v_s2 |-> $past(v_s1))
		else $error("accumulate pipeline out of step");

endmodule
